/* rtl/nbs_pkg.sv */
// ----------------------------------------------------------------------------
// nbs_pkg
// Shared types and constants of the box suppressor.
// ----------------------------------------------------------------------------
package nbs_pkg;

	localparam int MAX_BOXES = 1024;
	localparam int ADDR_W    = $clog2(MAX_BOXES);
	localparam int CNT_W     = $clog2(MAX_BOXES + 1);

	localparam logic [15:0] THR_RESET = 16'd29491;

	typedef struct packed {
		logic signed [15:0] cx;
		logic signed [15:0] cy;
		logic        [14:0] w;
		logic        [14:0] h;
	} geom_t;

	typedef struct packed {
		logic [15:0] score;
		geom_t       g;
	} entry_t;

	typedef struct packed {
		logic done;
		logic suppress;
	} iou_res_t;

endpackage

/* rtl/nbs_ifs.sv */
// ----------------------------------------------------------------------------
// nbs_ifs
// Box channel and result channel of the box suppressor.
// ----------------------------------------------------------------------------
interface nbs_box_if;
	logic               valid;
	logic               ready;
	logic               operation;
	logic signed [15:0] center_x;
	logic signed [15:0] center_y;
	logic        [14:0] box_width;
	logic        [14:0] box_height;
	logic        [15:0] class_score;
	logic               is_empty;
	logic               last_box;

	modport source (output valid, operation, center_x, center_y, box_width, box_height,
		class_score, is_empty, last_box, input ready);
	modport sink (input valid, operation, center_x, center_y, box_width, box_height,
		class_score, is_empty, last_box, output ready);
endinterface

interface nbs_res_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] out_center_x;
	logic signed [15:0] out_center_y;
	logic        [14:0] out_width;
	logic        [14:0] out_height;
	logic        [15:0] final_score;
	logic               final_entry;
	logic               none_left;

	modport source (output valid, out_center_x, out_center_y, out_width, out_height,
		final_score, final_entry, none_left, input ready);
	modport sink (input valid, out_center_x, out_center_y, out_width, out_height,
		final_score, final_entry, none_left, output ready);
endinterface

/* rtl/nbs_iou.sv */
// ----------------------------------------------------------------------------
// nbs_iou
// Pipelined overlap test: intersection * 65536 > threshold * union.
// ----------------------------------------------------------------------------
module nbs_iou import nbs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  geom_t       geo_a,
	input  geom_t       geo_b,
	input  logic [29:0] area_a,
	input  logic [15:0] thr,
	output iou_res_t    res
);

	logic signed [19:0] axl, axr, bxl, bxr, ayl, ayr, byl, byr;
	logic signed [19:0] xl, xr, yl, yr;

	logic               v_s1, v_s2, v_s3, v_s4;
	logic signed [19:0] ow_s1, oh_s1;
	logic        [29:0] areab_s1, areaa_s1, areaa_s2, areab_s2;
	logic        [33:0] inter_s2, uni_s3;
	logic        [49:0] lhs_s3, lhs_s4, rhs_s4;

	always_comb begin
		axl = ($signed({{4{geo_a.cx[15]}}, geo_a.cx}) <<< 1) - $signed({5'b0, geo_a.w});
		axr = ($signed({{4{geo_a.cx[15]}}, geo_a.cx}) <<< 1) + $signed({5'b0, geo_a.w});
		bxl = ($signed({{4{geo_b.cx[15]}}, geo_b.cx}) <<< 1) - $signed({5'b0, geo_b.w});
		bxr = ($signed({{4{geo_b.cx[15]}}, geo_b.cx}) <<< 1) + $signed({5'b0, geo_b.w});
		ayl = ($signed({{4{geo_a.cy[15]}}, geo_a.cy}) <<< 1) - $signed({5'b0, geo_a.h});
		ayr = ($signed({{4{geo_a.cy[15]}}, geo_a.cy}) <<< 1) + $signed({5'b0, geo_a.h});
		byl = ($signed({{4{geo_b.cy[15]}}, geo_b.cy}) <<< 1) - $signed({5'b0, geo_b.h});
		byr = ($signed({{4{geo_b.cy[15]}}, geo_b.cy}) <<< 1) + $signed({5'b0, geo_b.h});
		xl = (axl > bxl) ? axl : bxl;
		xr = (axr < bxr) ? axr : bxr;
		yl = (ayl > byl) ? ayl : byl;
		yr = (ayr < byr) ? ayr : byr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		ow_s1    <= xr - xl;
		oh_s1    <= yr - yl;
		areab_s1 <= 30'(geo_b.w * geo_b.h);
		areaa_s1 <= area_a;
		if (ow_s1 < 0 || oh_s1 < 0) begin
			inter_s2 <= '0;
		end else begin
			inter_s2 <= 34'(ow_s1[16:0] * oh_s1[16:0]);
		end
		areaa_s2 <= areaa_s1;
		areab_s2 <= areab_s1;
		uni_s3   <= {2'b0, areaa_s2, 2'b0} + {2'b0, areab_s2, 2'b0} - inter_s2;
		lhs_s3   <= {inter_s2, 16'b0};
		lhs_s4   <= lhs_s3;
		rhs_s4   <= 50'(thr * uni_s3);
	end

	assign res.done     = v_s4;
	assign res.suppress = lhs_s4 > rhs_s4;

endmodule

/* rtl/nms_box_suppressor.sv */
// ----------------------------------------------------------------------------
// nms_box_suppressor
// Greedy non-maximum suppression for one class over up to 1024 boxes.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      words
//  box_in    in    valid/ready    load or read request
//  res_out   out   valid/ready    one result word per read
//  cfg_wr    in    enable only    IoU threshold
//
// A load is written to the load memory as it is accepted; a read that finds a box goes through the read-wait state.
// A last load that leaves at least one box starts a rank sort through the load memory, then
// a suppression walk through the sorted memory.
// Reset clears the count, read position and ready flag; the memories are not cleared.
// A word is taken while a result waits only in the cycle that the result leaves.
module nms_box_suppressor import nbs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	nbs_box_if.sink     box_in,
	nbs_res_if.source   res_out
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RISS  = 4'd1;
	localparam logic [3:0] ST_RGET  = 4'd2;
	localparam logic [3:0] ST_RSCAN = 4'd3;
	localparam logic [3:0] ST_PISS  = 4'd4;
	localparam logic [3:0] ST_PGET  = 4'd5;
	localparam logic [3:0] ST_PRDJ  = 4'd6;
	localparam logic [3:0] ST_PSTRT = 4'd7;
	localparam logic [3:0] ST_PRUN  = 4'd8;
	localparam logic [3:0] ST_RDW   = 4'd9;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BOXES);
	localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

	entry_t mem_a [MAX_BOXES];
	entry_t mem_b [MAX_BOXES];

	logic              a_we, b_we;
	logic [ADDR_W-1:0] a_waddr, a_raddr, b_waddr, b_raddr;
	entry_t            a_wdata, a_rdata, b_wdata, b_rdata;

	logic [3:0]       state_q;
	logic [15:0]      thr_q;
	logic [CNT_W-1:0] cnt_q, rdpos_q, i_q, j_q, rank_q, last_kept_q;
	logic             ready_q, has_kept_q;
	entry_t           cur_q;
	geom_t            geo_a_q;
	logic [29:0]      area_a_q;

	logic               out_v_q, out_fin_q, out_none_q;
	logic signed [15:0] out_cx_q, out_cy_q;
	logic        [14:0] out_w_q, out_h_q;
	logic        [15:0] out_s_q;

	logic             accept, take_box, hit, iou_start;
	logic [CNT_W-1:0] base, rank_nx;
	iou_res_t         iou_res;

	assign box_in.ready = (state_q == ST_IDLE) && (!out_v_q || res_out.ready);
	assign accept       = box_in.valid && box_in.ready;
	assign base         = ready_q ? '0 : cnt_q;
	assign take_box     = !box_in.is_empty && (base < MAX_CNT);
	assign hit          = (a_rdata.score > cur_q.score) ||
		((a_rdata.score == cur_q.score) && (j_q < i_q));
	assign rank_nx      = rank_q + CNT_W'(hit);
	assign iou_start    = (state_q == ST_PSTRT);

	always_comb begin
		a_we    = accept && !box_in.operation && take_box;
		a_waddr = base[ADDR_W-1:0];
		a_wdata = '{score: box_in.class_score, g: '{cx: box_in.center_x,
			cy: box_in.center_y, w: box_in.box_width, h: box_in.box_height}};
		b_we    = 1'b0;
		b_waddr = rank_nx[ADDR_W-1:0];
		b_wdata = cur_q;
		unique case (state_q)
			ST_RISS: a_raddr = i_q[ADDR_W-1:0];
			ST_RSCAN: a_raddr = ADDR_W'(j_q + ONE);
			default: a_raddr = '0;
		endcase
		unique case (state_q)
			ST_PISS: b_raddr = i_q[ADDR_W-1:0];
			ST_PRDJ: b_raddr = j_q[ADDR_W-1:0];
			default: b_raddr = rdpos_q[ADDR_W-1:0];
		endcase
		if (state_q == ST_RSCAN && j_q == cnt_q - ONE) begin
			b_we = 1'b1;
		end
		if (state_q == ST_PRUN && iou_res.done && iou_res.suppress) begin
			b_we    = 1'b1;
			b_waddr = j_q[ADDR_W-1:0];
			b_wdata = '{score: 16'd0, g: cur_q.g};
		end
	end

	always_ff @(posedge clk) begin
		if (a_we) begin
			mem_a[a_waddr] <= a_wdata;
		end
		a_rdata <= mem_a[a_raddr];
		if (b_we) begin
			mem_b[b_waddr] <= b_wdata;
		end
		b_rdata <= mem_b[b_raddr];
	end

	nbs_iou u_iou (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (iou_start),
		.geo_a  (geo_a_q),
		.geo_b  (b_rdata.g),
		.area_a (area_a_q),
		.thr    (thr_q),
		.res    (iou_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			thr_q       <= THR_RESET;
			cnt_q       <= '0;
			rdpos_q     <= '0;
			ready_q     <= 1'b0;
			has_kept_q  <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			rank_q      <= '0;
			last_kept_q <= '0;
			out_v_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				thr_q <= cfg_wr_data;
			end
			if (out_v_q && res_out.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && !box_in.operation) begin
						ready_q <= 1'b0;
						rdpos_q <= '0;
						cnt_q   <= base + CNT_W'(take_box);
						if (box_in.last_box) begin
							has_kept_q <= 1'b0;
							i_q        <= '0;
							if (base + CNT_W'(take_box) == '0) begin
								ready_q <= 1'b1;
							end else begin
								state_q <= ST_RISS;
							end
						end
					end else if (accept) begin
						if (!ready_q || rdpos_q >= cnt_q) begin
							out_v_q    <= 1'b1;
							out_none_q <= 1'b1;
							out_fin_q  <= 1'b0;
							out_cx_q   <= '0;
							out_cy_q   <= '0;
							out_w_q    <= '0;
							out_h_q    <= '0;
							out_s_q    <= '0;
						end else begin
							state_q <= ST_RDW;
						end
					end
				end
				ST_RDW: begin
					out_v_q    <= 1'b1;
					out_none_q <= 1'b0;
					out_cx_q   <= b_rdata.g.cx;
					out_cy_q   <= b_rdata.g.cy;
					out_w_q    <= b_rdata.g.w;
					out_h_q    <= b_rdata.g.h;
					out_s_q    <= b_rdata.score;
					out_fin_q  <= (b_rdata.score != '0) && has_kept_q &&
						(last_kept_q == rdpos_q);
					rdpos_q    <= rdpos_q + ONE;
					state_q    <= ST_IDLE;
				end
				ST_RISS: state_q <= ST_RGET;
				ST_RGET: begin
					cur_q   <= a_rdata;
					j_q     <= '0;
					rank_q  <= '0;
					state_q <= ST_RSCAN;
				end
				ST_RSCAN: begin
					rank_q <= rank_nx;
					j_q    <= j_q + ONE;
					if (j_q == cnt_q - ONE) begin
						if (i_q + ONE == cnt_q) begin
							i_q     <= '0;
							state_q <= ST_PISS;
						end else begin
							i_q     <= i_q + ONE;
							state_q <= ST_RISS;
						end
					end
				end
				ST_PISS: state_q <= ST_PGET;
				ST_PGET: begin
					if (b_rdata.score == '0) begin
						if (i_q + ONE == cnt_q) begin
							ready_q <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							i_q     <= i_q + ONE;
							state_q <= ST_PISS;
						end
					end else begin
						geo_a_q     <= b_rdata.g;
						area_a_q    <= 30'(b_rdata.g.w * b_rdata.g.h);
						last_kept_q <= i_q;
						has_kept_q  <= 1'b1;
						if (i_q + ONE == cnt_q) begin
							ready_q <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							j_q     <= i_q + ONE;
							state_q <= ST_PRDJ;
						end
					end
				end
				ST_PRDJ: state_q <= ST_PSTRT;
				ST_PSTRT: begin
					cur_q   <= b_rdata;
					state_q <= ST_PRUN;
				end
				ST_PRUN: begin
					if (iou_res.done) begin
						if (j_q + ONE == cnt_q) begin
							i_q     <= i_q + ONE;
							state_q <= ST_PISS;
						end else begin
							j_q     <= j_q + ONE;
							state_q <= ST_PRDJ;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_out.valid        = out_v_q;
	assign res_out.out_center_x = out_cx_q;
	assign res_out.out_center_y = out_cy_q;
	assign res_out.out_width    = out_w_q;
	assign res_out.out_height   = out_h_q;
	assign res_out.final_score  = out_s_q;
	assign res_out.final_entry  = out_fin_q;
	assign res_out.none_left    = out_none_q;

	a_rank_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RSCAN |-> rank_q < cnt_q && i_q < cnt_q)
		else $error("rank out of range");

	a_rdpos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> rdpos_q <= cnt_q)
		else $error("read position past count");

	a_kept_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q && has_kept_q |-> last_kept_q < cnt_q)
		else $error("last kept index past count");

	a_inner_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PRUN |-> j_q > i_q && j_q < cnt_q)
		else $error("inner index out of order");

	a_iou_wait: assert property (@(posedge clk) disable iff (!arst_n)
		iou_res.done |-> state_q == ST_PRUN)
		else $error("overlap result outside wait state");

endmodule

/* bench/tb_nms_box_suppressor.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nms_box_suppressor
// Self-checking bench for the box suppressor. Box sets are loaded, the last
// load starts the sort and suppression pass, and reads return the sorted boxes.
// A built-in predictor computes every read result. Both channels idle at random outside the quiet phase.
// ----------------------------------------------------------------------------
module tb_nms_box_suppressor;
	import nbs_pkg::*;

	localparam bit OP_LOAD = 1'b0;
	localparam bit OP_READ = 1'b1;
	localparam longint CYCLE_LIMIT = 40_000_000;

	typedef struct {
		bit               op;
		logic signed [15:0] cx;
		logic signed [15:0] cy;
		logic [14:0]      w;
		logic [14:0]      h;
		logic [15:0]      score;
		bit               empty;
		bit               last;
		bit               expect_none;
	} box_word_t;

	typedef struct {
		logic signed [15:0] cx;
		logic signed [15:0] cy;
		logic [14:0]      w;
		logic [14:0]      h;
		logic [15:0]      score;
		logic             fin;
		logic             none;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;

	nbs_box_if box_if ();
	nbs_res_if res_if ();

	nms_box_suppressor dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.box_in(box_if),
		.res_out(res_if)
	);

	geom_t       kept_geom [MAX_BOXES];
	logic [15:0] kept_score [MAX_BOXES];
	int          box_count = 0;
	int          read_pos = 0;
	bit          sorted_ready = 0;
	logic [15:0] iou_thr = THR_RESET;

	result_t expected_results[$];
	int      fail_count = 0;
	longint  cycle_count = 0;
	bit      quiet = 0;

	always #10 clk = ~clk;

	initial begin
		box_if.valid = 1'b0;
		box_if.operation = OP_LOAD;
		box_if.center_x = '0;
		box_if.center_y = '0;
		box_if.box_width = '0;
		box_if.box_height = '0;
		box_if.class_score = '0;
		box_if.is_empty = 1'b0;
		box_if.last_box = 1'b0;
		res_if.ready = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			res_if.ready <= 1'b0;
		else
			res_if.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 23);
	end

	function automatic longint overlap2(longint c1, longint s1, longint c2, longint s2);
		longint lo;
		longint hi;
		lo = (2 * c1 - s1 > 2 * c2 - s2) ? 2 * c1 - s1 : 2 * c2 - s2;
		hi = (2 * c1 + s1 < 2 * c2 + s2) ? 2 * c1 + s1 : 2 * c2 + s2;
		return hi - lo;
	endfunction

	function automatic bit too_close(geom_t a, geom_t b);
		longint ow;
		longint oh;
		longint inter;
		longint uni;
		ow = overlap2(a.cx, a.w, b.cx, b.w);
		oh = overlap2(a.cy, a.h, b.cy, b.h);
		inter = (ow < 0 || oh < 0) ? 0 : ow * oh;
		uni = 4 * longint'(a.w) * longint'(a.h) + 4 * longint'(b.w) * longint'(b.h) - inter;
		return inter * 65536 > longint'(iou_thr) * uni;
	endfunction

	task automatic sort_and_suppress();
		geom_t g;
		logic [15:0] s;
		int j;
		for (int i = 1; i < box_count; i++) begin
			g = kept_geom[i];
			s = kept_score[i];
			j = i;
			while (j > 0 && kept_score[j - 1] < s) begin
				kept_geom[j] = kept_geom[j - 1];
				kept_score[j] = kept_score[j - 1];
				j--;
			end
			kept_geom[j] = g;
			kept_score[j] = s;
		end
		for (int i = 0; i < box_count; i++) begin
			if (kept_score[i] != 0)
				for (int k = i + 1; k < box_count; k++)
					if (too_close(kept_geom[i], kept_geom[k]))
						kept_score[k] = '0;
		end
	endtask

	task automatic predict_word(box_word_t b);
		result_t r;
		bit later_kept;
		if (b.op == OP_LOAD) begin
			if (sorted_ready) begin
				sorted_ready = 0;
				box_count = 0;
				read_pos = 0;
			end
			if (!b.empty && box_count < MAX_BOXES) begin
				kept_geom[box_count] = '{cx: b.cx, cy: b.cy, w: b.w, h: b.h};
				kept_score[box_count] = b.score;
				box_count++;
			end
			if (b.last) begin
				sort_and_suppress();
				read_pos = 0;
				sorted_ready = 1;
			end
			return;
		end
		r = '{default: '0};
		if (!sorted_ready || read_pos >= box_count) begin
			r.none = 1'b1;
		end else begin
			later_kept = 0;
			for (int k = read_pos + 1; k < box_count; k++)
				if (kept_score[k] != 0)
					later_kept = 1;
			r.cx = kept_geom[read_pos].cx;
			r.cy = kept_geom[read_pos].cy;
			r.w = kept_geom[read_pos].w;
			r.h = kept_geom[read_pos].h;
			r.score = kept_score[read_pos];
			r.fin = (kept_score[read_pos] != 0) && !later_kept;
			read_pos++;
		end
		expected_results.push_back(r);
	endtask

	always @(posedge clk) begin
		result_t e;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (expected_results.size() == 0) begin
				$error("result word with no expectation pending");
				fail_count++;
			end else begin
				e = expected_results.pop_front();
				if (res_if.out_center_x !== e.cx) begin
					$error("out_center_x expected %0d actual %0d", e.cx, res_if.out_center_x);
					fail_count++;
				end
				if (res_if.out_center_y !== e.cy) begin
					$error("out_center_y expected %0d actual %0d", e.cy, res_if.out_center_y);
					fail_count++;
				end
				if (res_if.out_width !== e.w) begin
					$error("out_width expected %0d actual %0d", e.w, res_if.out_width);
					fail_count++;
				end
				if (res_if.out_height !== e.h) begin
					$error("out_height expected %0d actual %0d", e.h, res_if.out_height);
					fail_count++;
				end
				if (res_if.final_score !== e.score) begin
					$error("final_score expected %0d actual %0d", e.score, res_if.final_score);
					fail_count++;
				end
				if (res_if.final_entry !== e.fin) begin
					$error("final_entry expected %0d actual %0d", e.fin, res_if.final_entry);
					fail_count++;
				end
				if (res_if.none_left !== e.none) begin
					$error("none_left expected %0d actual %0d", e.none, res_if.none_left);
					fail_count++;
				end
			end
		end
	end

	task automatic send_word(box_word_t b);
		result_t typed;
		while (!quiet && $urandom_range(99) < 23) begin
			box_if.valid <= 1'b0;
			@(posedge clk);
		end
		box_if.valid <= 1'b1;
		box_if.operation <= b.op;
		box_if.center_x <= b.cx;
		box_if.center_y <= b.cy;
		box_if.box_width <= b.w;
		box_if.box_height <= b.h;
		box_if.class_score <= b.score;
		box_if.is_empty <= b.empty;
		box_if.last_box <= b.last;
		do @(posedge clk); while (!(box_if.valid && box_if.ready));
		predict_word(b);
		if (b.expect_none) begin
			typed = '{default: '0};
			typed.none = 1'b1;
			expected_results[expected_results.size() - 1] = typed;
		end
	endtask

	task automatic settle_and_write(logic [15:0] thr);
		box_if.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		do @(posedge clk); while (!box_if.ready);
		repeat (12) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= thr;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		iou_thr = thr;
	endtask

	function automatic box_word_t load_word(int cx, int cy, int w, int h, int score,
			bit empty, bit last);
		box_word_t b;
		b = '{op: OP_LOAD, cx: 16'(cx), cy: 16'(cy), w: 15'(w), h: 15'(h),
			score: 16'(score), empty: empty, last: last, expect_none: 0};
		return b;
	endfunction

	function automatic box_word_t read_word(bit typed_none);
		box_word_t b;
		b = '{default: '0};
		b.op = OP_READ;
		b.cx = 16'($urandom);
		b.cy = 16'($urandom);
		b.w = 15'($urandom);
		b.h = 15'($urandom);
		b.score = 16'($urandom);
		b.empty = 1'($urandom);
		b.last = 1'($urandom);
		b.expect_none = typed_none;
		return b;
	endfunction

	function automatic box_word_t random_load(bit wide, int base_x, int base_y, bit last);
		box_word_t b;
		int pick;
		b = read_word(0);
		b.op = OP_LOAD;
		b.expect_none = 0;
		b.last = last;
		b.empty = ($urandom_range(99) < 10);
		if (!wide) begin
			b.cx = 16'(base_x + $urandom_range(0, 3000) - 1500);
			b.cy = 16'(base_y + $urandom_range(0, 3000) - 1500);
			b.w = 15'($urandom_range(0, 8192));
			b.h = 15'($urandom_range(0, 8192));
		end
		pick = $urandom_range(3);
		if (pick == 0)
			b.score = 16'($urandom_range(0, 3) * 16384);
		else if (pick == 1)
			b.score = 0;
		return b;
	endfunction

	initial begin
		box_word_t directed [$];
		int n_loads;
		int n_sets;
		logic [15:0] thr_choice [4];

		thr_choice = '{16'd0, 16'd65535, THR_RESET, 16'd0};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed.push_back(read_word(1));
		directed.push_back(load_word(-32768, 32767, 32767, 0, 65535, 0, 0));
		directed.push_back(load_word(32767, -32768, 0, 32767, 0, 0, 0));
		directed.push_back(load_word(0, 0, 4096, 4096, 1234, 1, 0));
		directed.push_back(read_word(1));
		directed.push_back(load_word(0, 0, 4096, 4096, 40000, 0, 0));
		directed.push_back(load_word(100, 0, 4096, 4096, 40000, 0, 0));
		directed.push_back(load_word(20000, 20000, 4096, 4096, 40000, 0, 0));
		directed.push_back(load_word(0, 0, 0, 0, 500, 1, 1));
		for (int i = 0; i < 5; i++) directed.push_back(read_word(0));
		directed.push_back(read_word(1));
		directed.push_back(load_word(5, 5, 0, 0, 700, 0, 0));
		directed.push_back(load_word(5, 5, 0, 0, 600, 0, 1));
		directed.push_back(read_word(0));
		directed.push_back(read_word(0));
		directed.push_back(read_word(1));
		foreach (directed[i]) send_word(directed[i]);

		settle_and_write(16'd65535);

		// Overfill the store with identical boxes; all but the best are suppressed.
		for (int i = 0; i < MAX_BOXES + 6; i++)
			send_word(load_word(300, -300, 2048, 2048, $urandom, 0, i == MAX_BOXES + 5));
		for (int i = 0; i < 4; i++) send_word(read_word(0));

		n_sets = 0;
		n_loads = 0;
		while (n_loads < 120) begin
			int set_size;
			int bx;
			int by;
			bit wide;
			if (n_sets % 6 == 5)
				settle_and_write(($urandom_range(3) == 0) ? 16'($urandom) :
					thr_choice[$urandom_range(3)]);
			quiet = (n_loads >= 40 && n_loads < 80);
			set_size = $urandom_range(1, 12);
			bx = $urandom_range(0, 40000) - 20000;
			by = $urandom_range(0, 40000) - 20000;
			wide = ($urandom_range(99) < 20);
			for (int i = 0; i < set_size; i++) begin
				if ($urandom_range(99) < 4) send_word(read_word(0));
				send_word(random_load(wide, bx, by, i == set_size - 1));
				n_loads++;
			end
			if ($urandom_range(99) < 8)
				continue;
			for (int i = 0; i < set_size + $urandom_range(0, 2); i++)
				send_word(read_word(0));
			n_sets++;
		end
		quiet = 0;

		box_if.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* files.f */
rtl/nbs_pkg.sv
rtl/nbs_ifs.sv
rtl/nbs_iou.sv
rtl/nms_box_suppressor.sv
bench/tb_nms_box_suppressor.sv
